FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TIA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TIA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tia_pkg.sv
// types, codes and defaults for the tile index allocator
// no dependencies
package tia_pkg;

    localparam int MAX_TILES_DEF = 1024;
    localparam int NO_TILE_DEF   = 65535;
    localparam int CAP_RESET     = 1024;

    localparam int CAP_W      = 11;
    localparam int TILE_W     = 16;
    localparam int GRANT_W    = 10;
    localparam int STAT_W     = 3;
    localparam int USED_W     = 11;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [STAT_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

FILE: hw/rtl/tile_index_allocator_core.sv
// top level of the tile index allocator: controller plus datapath
// depends on tia_pkg, tia_ctrl, tia_datapath
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  s       | i_s_tvalid/o_s_tready  | tuser op, tdata tile_index
//  m       | o_m_tvalid/i_m_tready  | tuser status, tdata granted_tile,used_count
//  cfg     | i_cfg_valid/o_cfg_ready| capacity, pool reinitialized on write
//
// every transaction is accepted with the stack or flag ram read, then executed:
// execute uses the registered read data and writes back.
// synchronous active-low reset loads the default capacity; no clearing pass,
// untouched stack slots and flags are tracked by the lowest free count.
// a full result register stalls execute, and no new item is accepted while it waits.
module tile_index_allocator_core
    import tia_pkg::*;
#(
    parameter int MAX_TILES = MAX_TILES_DEF,
    parameter int NO_TILE   = NO_TILE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [TILE_W-1:0]     i_s_tdata,  // [15:0] tile_index
    input  logic                  i_s_tuser,  // [0] op
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,  // [9:0] granted_tile, [20:10] used_count
    output logic [STAT_W-1:0]     o_m_tuser,  // [2:0] status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CAP_W-1:0]      i_cfg_data
);

    t_cmd               cmd;
    logic [GRANT_W-1:0] granted;
    t_status            status;
    logic [USED_W-1:0]  used;

    assign o_cfg_ready = 1'b1;

    tia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    tia_datapath #(
        .MAX_TILES (MAX_TILES),
        .NO_TILE   (NO_TILE)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_cap (i_cfg_data),
        .i_op      (t_op'(i_s_tuser)),
        .i_tile    (i_s_tdata),
        .o_granted (granted),
        .o_status  (status),
        .o_used    (used)
    );

    assign o_m_tdata = {(OUT_DATA_W - USED_W - GRANT_W)'(0), used, granted};
    assign o_m_tuser = status;

endmodule

FILE: hw/rtl/tia_ram.sv
// generic single-port ram with registered read
// no dependencies
module tia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tia_ctrl.sv
// controller: accept / execute sequencing and output valid
// depends on tia_pkg
module tia_ctrl
    import tia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = slot_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // result register stays full until the sink takes it
    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

FILE: hw/rtl/tia_datapath.sv
// datapath: free stack, in-use flags, counters and result register
// depends on tia_pkg and tia_ram
module tia_datapath
    import tia_pkg::*;
#(
    parameter int MAX_TILES = MAX_TILES_DEF,
    parameter int NO_TILE   = NO_TILE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CAP_W-1:0]   i_cfg_cap,
    input  t_op                i_op,
    input  logic [TILE_W-1:0]  i_tile,
    output logic [GRANT_W-1:0] o_granted,
    output t_status            o_status,
    output logic [USED_W-1:0]  o_used
);

    localparam int IW     = $clog2(MAX_TILES);
    localparam int CW     = $clog2(MAX_TILES + 1);
    localparam int LIMIT  = (MAX_TILES < NO_TILE - 1) ? MAX_TILES : NO_TILE - 1;
    localparam int RST_SZ = (CAP_RESET < LIMIT) ? CAP_RESET : LIMIT;

    logic [CW-1:0] r_pool;
    logic [CW-1:0] r_free;
    logic [CW-1:0] r_low;   // lowest free count since init; stack slots below it untouched
    logic [CW-1:0] r_used;
    logic [CW-1:0] n_free;
    logic [CW-1:0] n_low;
    logic [CW-1:0] n_used;
    logic [CW-1:0] cfg_pool;

    logic [TILE_W-1:0] r_tile;
    t_status           r_pre;
    logic              r_written;
    logic              r_pristine;
    t_status           n_pre;

    logic [GRANT_W-1:0] r_granted;
    t_status            r_status;
    logic [USED_W-1:0]  r_out_used;
    logic [GRANT_W-1:0] n_granted;
    t_status            n_status;

    logic          stk_we;
    logic          stk_re;
    logic [IW-1:0] stk_addr;
    logic [IW-1:0] stk_rdata;
    logic          flg_we;
    logic          flg_re;
    logic [IW-1:0] flg_addr;
    logic          flg_rdata;

    logic          do_alloc;
    logic          do_release;
    logic [IW-1:0] pop_val;

    assign cfg_pool = (32'(i_cfg_cap) > LIMIT) ? CW'(LIMIT) : CW'(i_cfg_cap);

    // decode what can be settled at accept time
    always_comb begin
        if (i_op == OP_ALLOC) begin
            n_pre = (r_free == '0) ? ST_EMPTY : ST_ALLOCATED;
        end else if (i_tile == TILE_W'(NO_TILE)) begin
            n_pre = ST_IGNORED;
        end else if (i_tile >= TILE_W'(r_pool)) begin
            n_pre = ST_RANGE;
        end else begin
            n_pre = ST_RELEASED;
        end
    end

    // untouched stack slot i holds pool - 1 - i, the pop at free - 1 gives pool - free
    assign pop_val    = r_pristine ? IW'(r_pool - r_free) : stk_rdata;
    assign do_alloc   = i_cmd.exec && (r_pre == ST_ALLOCATED);
    assign do_release = i_cmd.exec && (r_pre == ST_RELEASED) && r_written && flg_rdata;

    assign stk_re   = i_cmd.load && (i_op == OP_ALLOC);
    assign stk_we   = do_release;
    assign stk_addr = i_cmd.exec ? IW'(r_free) : IW'(r_free - CW'(1));

    assign flg_re   = i_cmd.load && (i_op == OP_RELEASE);
    assign flg_we   = do_alloc || do_release;
    always_comb begin
        if (do_alloc) begin
            flg_addr = pop_val;
        end else if (i_cmd.exec) begin
            flg_addr = IW'(r_tile);
        end else begin
            flg_addr = IW'(i_tile);
        end
    end

    tia_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_TILES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_re    (stk_re),
        .i_addr  (stk_addr),
        .i_wdata (IW'(r_tile)),
        .o_rdata (stk_rdata)
    );

    tia_ram #(
        .WIDTH (1),
        .DEPTH (MAX_TILES)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (flg_we),
        .i_re    (flg_re),
        .i_addr  (flg_addr),
        .i_wdata (do_alloc),
        .o_rdata (flg_rdata)
    );

    always_comb begin
        n_free    = r_free;
        n_low     = r_low;
        n_used    = r_used;
        n_granted = '0;
        n_status  = r_pre;
        if (do_alloc) begin
            n_free    = r_free - CW'(1);
            n_used    = r_used + CW'(1);
            n_granted = GRANT_W'(pop_val);
            if (r_pristine) begin
                n_low = r_free - CW'(1);
            end
        end else if (do_release) begin
            n_free = r_free + CW'(1);
            n_used = r_used - CW'(1);
        end else if (r_pre == ST_RELEASED) begin
            // tile not in use
            n_status = ST_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= CW'(RST_SZ);
            r_free <= CW'(RST_SZ);
            r_low  <= CW'(RST_SZ);
            r_used <= '0;
        end else if (i_cfg_we) begin
            r_pool <= cfg_pool;
            r_free <= cfg_pool;
            r_low  <= cfg_pool;
            r_used <= '0;
        end else if (i_cmd.exec) begin
            r_free <= n_free;
            r_low  <= n_low;
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tile     <= i_tile;
            r_pre      <= n_pre;
            // tiles at or above pool - low were never handed out since init
            r_written  <= (i_tile < TILE_W'(r_pool - r_low));
            r_pristine <= (r_free == r_low);
        end
        if (i_cmd.exec) begin
            r_granted  <= n_granted;
            r_status   <= n_status;
            r_out_used <= USED_W'(n_used);
        end
    end

    assign o_granted = r_granted;
    assign o_status  = r_status;
    assign o_used    = r_out_used;

endmodule

FILE: hw/rtl/tia_checker.sv
// port-level checker for the tile index allocator, bound to the top level
// depends on tia_pkg and assert_macros.svh
`include "assert_macros.svh"

module tia_checker
    import tia_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [TILE_W-1:0]     i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [STAT_W-1:0]     o_m_tuser,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CAP_W-1:0]      i_cfg_data
);

    `TIA_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")
    `TIA_ASSERT(a_busy_after_accept, i_s_tvalid && o_s_tready |=> !o_s_tready, "accepted a second item during execute")
    `TIA_ASSERT(a_alloc_counts, o_m_tvalid && o_m_tuser == ST_ALLOCATED |-> o_m_tdata[20:10] != '0, "allocation left used count at zero")
    `TIA_ASSERT(a_no_grant, o_m_tvalid && o_m_tuser != ST_ALLOCATED |-> o_m_tdata[9:0] == '0, "tile granted without allocation")

endmodule

bind tile_index_allocator_core tia_checker u_tia_checker (.*);

FILE: sim/tb_top.sv
// self-checking testbench for tile_index_allocator_core: directed and random
// allocate/release traffic against a tile pool tracker, across capacity writes
// depends on tia_pkg and tile_index_allocator_core
module tb_top;
    import tia_pkg::*;

    typedef struct {
        bit [GRANT_W-1:0] granted;
        t_status          status;
        bit [USED_W-1:0]  used;
    } t_grant;

    // tracks the free stack, in-use flags and used count of the pool
    class tile_pool_scoreboard;
        bit [GRANT_W-1:0] free_stack [MAX_TILES_DEF];
        bit               in_use [MAX_TILES_DEF];
        int unsigned      free_cnt;
        int unsigned      pool_size;
        int unsigned      used_cnt;
        t_grant           expected_grants [$];
        int unsigned      err_cnt;

        function void load_capacity(int unsigned cap);
            int unsigned n;
            n = cap;
            if (n > MAX_TILES_DEF) n = MAX_TILES_DEF;
            if (n > NO_TILE_DEF - 1) n = NO_TILE_DEF - 1;
            pool_size = n;
            for (int i = 0; i < MAX_TILES_DEF; i++) begin
                free_stack[i] = '0;
                in_use[i]     = 1'b0;
            end
            // descending, so tile zero is on top
            for (int i = 0; i < n; i++) begin
                free_stack[i] = GRANT_W'(n - 1 - i);
            end
            free_cnt = n;
            used_cnt = 0;
        endfunction

        function void note_request(t_op op, bit [TILE_W-1:0] tile);
            t_grant g;
            g.granted = '0;
            if (op == OP_ALLOC) begin
                if (free_cnt == 0) begin
                    g.status = ST_EMPTY;
                end else begin
                    free_cnt--;
                    g.granted = free_stack[free_cnt];
                    in_use[g.granted] = 1'b1;
                    used_cnt++;
                    g.status = ST_ALLOCATED;
                end
            end else if (tile == TILE_W'(NO_TILE_DEF)) begin
                g.status = ST_IGNORED;
            end else if (tile >= pool_size || tile >= MAX_TILES_DEF) begin
                g.status = ST_RANGE;
            end else if (!in_use[tile]) begin
                g.status = ST_IGNORED;
            end else begin
                in_use[tile] = 1'b0;
                if (used_cnt > 0) used_cnt--;
                if (free_cnt < MAX_TILES_DEF) begin
                    free_stack[free_cnt] = tile[GRANT_W-1:0];
                    free_cnt++;
                end
                g.status = ST_RELEASED;
            end
            g.used = USED_W'(used_cnt);
            expected_grants.insert(expected_grants.size(), g);
        endfunction

        // a tile that is allocated right now, or any in-range one if none is (0 to 3 for an empty pool)
        function bit [TILE_W-1:0] pick_used_tile();
            int unsigned start;
            int unsigned idx;
            if (pool_size == 0) return TILE_W'($urandom_range(0, 3));
            start = $urandom_range(0, pool_size - 1);
            for (int i = 0; i < pool_size; i++) begin
                idx = (start + i) % pool_size;
                if (in_use[idx]) return TILE_W'(idx);
            end
            return TILE_W'(start);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            err_cnt++;
        endtask

        task check_grant(logic [OUT_DATA_W-1:0] tdata, logic [STAT_W-1:0] tuser);
            t_grant g;
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%h",
                                          tdata, tuser));
                return;
            end
            g = expected_grants.pop_front();
            if (tdata[GRANT_W-1:0] !== g.granted)
                report_mismatch($sformatf("granted_tile %0d, want %0d",
                                          tdata[GRANT_W-1:0], g.granted));
            if (tuser !== g.status)
                report_mismatch($sformatf("status %0d, want %0d", tuser, g.status));
            if (tdata[GRANT_W +: USED_W] !== g.used)
                report_mismatch($sformatf("used_count %0d, want %0d",
                                          tdata[GRANT_W +: USED_W], g.used));
            if (tdata[OUT_DATA_W-1:GRANT_W+USED_W] !== '0)
                report_mismatch($sformatf("tdata padding %h not zero", tdata));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [TILE_W-1:0]     i_s_tdata;   // [15:0] tile_index
    logic                  i_s_tuser;   // [0] op
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [9:0] granted_tile, [20:10] used_count
    logic [STAT_W-1:0]     o_m_tuser;   // [2:0] status
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CAP_W-1:0]      i_cfg_data;

    tile_pool_scoreboard sb;
    bit                  idle_on;
    int unsigned         rx_hold_cycles;

    tile_index_allocator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // valid stays high into the next transaction when there is no gap
    task send_request(t_op op, bit [TILE_W-1:0] tile);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= tile;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(op, tile);
    endtask

    task wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.expected_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_capacity(int unsigned cap);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CAP_W'(cap);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.load_capacity(cap);
        repeat (2) @(posedge i_clk);
    endtask

    task random_request(int unsigned alloc_pct);
        int unsigned r;
        bit [TILE_W-1:0] tile;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            send_request(OP_ALLOC, TILE_W'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70)
                tile = sb.pick_used_tile();
            else if (r < 85)
                tile = (sb.pool_size > 0) ? TILE_W'($urandom_range(0, sb.pool_size - 1))
                                          : TILE_W'($urandom);
            else if (r < 93)
                tile = TILE_W'($urandom);
            else
                tile = TILE_W'(NO_TILE_DEF);
            send_request(OP_RELEASE, tile);
        end
    endtask

    task run_phase(int unsigned cap, int unsigned n, int unsigned alloc_pct, bit idle,
                   int unsigned hold);
        write_capacity(cap);
        idle_on        = idle;
        rx_hold_cycles = hold;
        repeat (n) random_request(alloc_pct);
    endtask

    // result side
    initial begin
        int unsigned gap;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                // long back-pressure so the block fills and stalls its input
                i_m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_grant(o_m_tdata, o_m_tuser);
        end
    end

    initial begin
        #6000000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        sb = new();
        sb.load_capacity(CAP_RESET);
        idle_on        = 1'b1;
        rx_hold_cycles = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tuser   <= OP_ALLOC;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default pool: in-order grants, reuse, double release, sentinel, range
        send_request(OP_ALLOC, 16'hFFFF);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_ALLOC, 16'h5A5A);
        send_request(OP_RELEASE, 16'd1);
        send_request(OP_ALLOC, 16'hA5A5);
        send_request(OP_RELEASE, 16'd1);
        send_request(OP_RELEASE, 16'd1);
        send_request(OP_RELEASE, 16'd5);
        send_request(OP_RELEASE, TILE_W'(NO_TILE_DEF));
        send_request(OP_RELEASE, 16'd1024);
        send_request(OP_RELEASE, 16'hFFFE);
        send_request(OP_RELEASE, 16'h8000);
        send_request(OP_RELEASE, 16'd0);
        send_request(OP_RELEASE, 16'd2);

        // zero capacity
        write_capacity(0);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_RELEASE, 16'd0);
        send_request(OP_RELEASE, TILE_W'(NO_TILE_DEF));

        // single tile: empty pool, release and re-grant
        write_capacity(1);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_RELEASE, 16'd0);
        send_request(OP_RELEASE, 16'd0);
        send_request(OP_ALLOC, 16'h0000);

        // capacity above the maximum is clamped
        write_capacity(2047);
        send_request(OP_ALLOC, 16'h0000);
        send_request(OP_RELEASE, 16'd1023);
        send_request(OP_RELEASE, 16'd1024);

        run_phase(0,    30,  50, 1'b1, 0);
        run_phase(1,    60,  50, 1'b0, 0);
        run_phase(2,    60,  55, 1'b1, 0);
        run_phase(5,    100, 60, 1'b1, 0);
        run_phase(17,   150, 60, 1'b1, 40);
        run_phase(2047, 250, 85, 1'b0, 60);
        run_phase(1024, 100, 50, 1'b1, 0);
        run_phase($urandom_range(3, 64), 100, 55, 1'b1, 0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: tile_index_allocator_core.f
+incdir+hw/rtl
hw/rtl/tia_pkg.sv
hw/rtl/tia_ram.sv
hw/rtl/tia_ctrl.sv
hw/rtl/tia_datapath.sv
hw/rtl/tile_index_allocator_core.sv
hw/rtl/tia_checker.sv
sim/tb_top.sv
